/* src/ttdg_pkg.sv */
package ttdg_pkg;

    // Build-time defaults
    localparam int unsigned CORDIC_STEPS_DEFAULT = 16;

    // Arctangent table: 24 entries, indexed by a 5-bit step count
    localparam int unsigned ATAN_DEPTH = 24;
    localparam int unsigned STEP_W     = 5;

    // Datapath widths
    localparam int unsigned CIN_W     = 34;  // CORDIC operand in
    localparam int unsigned CX_W      = 45;  // CORDIC x/y working width
    localparam int unsigned ANG_W     = 34;  // angle, Q28 radians
    localparam int unsigned E_W       = 35;  // angle difference
    localparam int unsigned ERR_W     = 18;  // heading error, signed Q5.12
    localparam int unsigned NUM_W     = 19;  // error difference
    localparam int unsigned DEN_W     = 32;  // time gap
    localparam int unsigned DIV_CNT_W = 5;
    localparam int unsigned DX_W      = 33;  // displacement
    localparam int unsigned PP_W      = 35;  // Kp * err
    localparam int unsigned PD_W      = 36;  // Kd * deriv
    localparam int unsigned ACC_W     = 40;  // PD sum
    localparam int unsigned SQ_W      = 62;  // squared magnitude
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 32;

    // Angle constants
    localparam logic signed [ANG_W-1:0] PI_ANG     = 34'sd843314857;
    localparam logic signed [E_W-1:0]   PI_E       = 35'sd843314857;
    localparam logic signed [E_W-1:0]   TWO_PI_E   = 35'sd1686629713;
    localparam logic signed [E_W-1:0]   E_HALF     = 35'sd32768;
    localparam logic signed [CX_W-1:0]  NORM_LIM   = 45'sh100_0000_0000;
    localparam logic signed [CIN_W-1:0] ONE_Q28    = 34'sd268435456;
    localparam logic signed [ACC_W-1:0] ACC_HALF   = 40'sd8192;
    localparam logic signed [ACC_W-1:0] SAT_HI     = 40'sd32767;
    localparam logic signed [ACC_W-1:0] SAT_LO     = -40'sd32768;

    // Commands
    localparam logic [1:0] CMD_START  = 2'd0;
    localparam logic [1:0] CMD_TICK   = 2'd1;
    localparam logic [1:0] CMD_CANCEL = 2'd2;

    // Status codes
    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_WAIT    = 3'd1;
    localparam logic [2:0] ST_SPIN    = 3'd2;
    localparam logic [2:0] ST_DRIVE   = 3'd3;
    localparam logic [2:0] ST_DONE    = 3'd4;
    localparam logic [2:0] ST_CANCEL  = 3'd5;
    localparam logic [2:0] ST_TIMEOUT = 3'd6;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAD_TOL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ARR_TOL  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CRUISE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 3'd5;

    // Register reset values
    localparam logic [15:0]        RST_GAIN_P   = 16'd3277;
    localparam logic [15:0]        RST_GAIN_D   = 16'd0;
    localparam logic [13:0]        RST_HEAD_TOL = 14'd819;
    localparam logic [30:0]        RST_ARR_TOL  = 31'd6554;
    localparam logic signed [15:0] RST_CRUISE   = 16'sd3277;
    localparam logic [15:0]        RST_TIMEOUT  = 16'd360;

    typedef struct packed {
        logic [1:0]         command;
        logic [31:0]        time_sec;
        logic               pose_ready;
        logic signed [31:0] pose_x;
        logic signed [31:0] pose_y;
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_z;
        logic signed [31:0] goal_x;
        logic signed [31:0] goal_y;
    } item_t;

    typedef struct packed {
        logic               drive_valid;
        logic signed [15:0] linear_speed;
        logic signed [15:0] turn_rate;
        logic [2:0]         status;
    } result_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_YAW_GO,
        S_YAW_WAIT,
        S_BEAR_GO,
        S_BEAR_WAIT,
        S_WRAP,
        S_ROUND,
        S_TEST,
        S_DIV_WAIT,
        S_MUL_P,
        S_MUL_D,
        S_SUM,
        S_DIST_X,
        S_DIST_Y,
        S_DIST_T,
        S_CMP,
        S_FINISH
    } ctl_state_t;

    typedef enum logic [1:0] {
        C_IDLE,
        C_NORM,
        C_ITER,
        C_DONE
    } cordic_state_t;

    // atan(2^-i) in Q28 radians
    function automatic logic signed [ANG_W-1:0] atan_entry(input logic [STEP_W-1:0] i);
        logic signed [ANG_W-1:0] v;
        begin
            unique case (i)
                5'd0:    v = 34'sd210828714;
                5'd1:    v = 34'sd124459457;
                5'd2:    v = 34'sd65760959;
                5'd3:    v = 34'sd33381290;
                5'd4:    v = 34'sd16755422;
                5'd5:    v = 34'sd8385879;
                5'd6:    v = 34'sd4193963;
                5'd7:    v = 34'sd2097109;
                5'd8:    v = 34'sd1048571;
                5'd9:    v = 34'sd524287;
                5'd10:   v = 34'sd262144;
                5'd11:   v = 34'sd131072;
                5'd12:   v = 34'sd65536;
                5'd13:   v = 34'sd32768;
                5'd14:   v = 34'sd16384;
                5'd15:   v = 34'sd8192;
                5'd16:   v = 34'sd4096;
                5'd17:   v = 34'sd2048;
                5'd18:   v = 34'sd1024;
                5'd19:   v = 34'sd512;
                5'd20:   v = 34'sd256;
                5'd21:   v = 34'sd128;
                5'd22:   v = 34'sd64;
                5'd23:   v = 34'sd32;
                default: v = '0;
            endcase
            return v;
        end
    endfunction

endpackage

/* src/ttdg_cordic.sv */
module ttdg_cordic #(
    parameter int unsigned STEPS = ttdg_pkg::CORDIC_STEPS_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               go,
    input  logic signed [ttdg_pkg::CIN_W-1:0]  y_in,
    input  logic signed [ttdg_pkg::CIN_W-1:0]  x_in,
    output logic                               done,
    output logic signed [ttdg_pkg::ANG_W-1:0]  angle
);
    import ttdg_pkg::*;

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(STEPS - 1);

    cordic_state_t           state_reg, state_next;
    logic signed [CX_W-1:0]  x_reg, x_next, y_reg, y_next;
    logic signed [ANG_W-1:0] ang_reg, ang_next;
    logic [STEP_W-1:0]       step_reg, step_next;
    logic signed [CX_W-1:0]  xs, ys;
    logic                    mag_low;

    // Shifted operands and the normalise test
    assign xs      = x_reg >>> step_reg;
    assign ys      = y_reg >>> step_reg;
    assign mag_low = (x_reg < NORM_LIM) && (x_reg > -NORM_LIM)
                  && (y_reg < NORM_LIM) && (y_reg > -NORM_LIM);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            C_IDLE:
            begin
                if (go)
                begin
                    state_next = (x_in == '0 && y_in == '0) ? C_DONE : C_NORM;
                end
            end
            C_NORM:
            begin
                if (!mag_low)
                begin
                    state_next = C_ITER;
                end
            end
            C_ITER:
            begin
                if (step_reg == LAST_STEP)
                begin
                    state_next = C_DONE;
                end
            end
            C_DONE:  state_next = C_IDLE;
            default: state_next = C_IDLE;
        endcase
    end

    // Datapath: load, normalise one bit a cycle, then rotate one step a cycle
    always_comb
    begin
        x_next    = x_reg;
        y_next    = y_reg;
        ang_next  = ang_reg;
        step_next = step_reg;
        unique case (state_reg)
            C_IDLE:
            begin
                if (go)
                begin
                    x_next    = CX_W'(x_in);
                    y_next    = CX_W'(y_in);
                    ang_next  = '0;
                    step_next = '0;
                end
            end
            C_NORM:
            begin
                if (mag_low)
                begin
                    x_next = x_reg <<< 1;
                    y_next = y_reg <<< 1;
                end
                else if (x_reg < 0)
                begin
                    ang_next = (y_reg >= 0) ? PI_ANG : -PI_ANG;
                    x_next   = -x_reg;
                    y_next   = -y_reg;
                end
            end
            C_ITER:
            begin
                if (y_reg > 0)
                begin
                    x_next   = x_reg + ys;
                    y_next   = y_reg - xs;
                    ang_next = ang_reg + atan_entry(step_reg);
                end
                else
                begin
                    x_next   = x_reg - ys;
                    y_next   = y_reg + xs;
                    ang_next = ang_reg - atan_entry(step_reg);
                end
                step_next = step_reg + STEP_W'(1);
            end
            C_DONE:
            begin
                step_next = step_reg;
            end
            default:
            begin
                step_next = step_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        ang_reg  <= ang_next;
        step_reg <= step_next;
    end

    assign done  = (state_reg == C_DONE);
    assign angle = ang_reg;

    // Checks
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("cordic done held longer than one cycle");

    a_go_idle: assert property (@(posedge clk) disable iff (!rst_n)
        go |-> state_reg == C_IDLE)
        else $error("cordic started while busy");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == C_ITER |-> step_reg <= LAST_STEP)
        else $error("cordic step beyond last");

endmodule

/* src/ttdg_divider.sv */
module ttdg_divider (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               go,
    input  logic signed [ttdg_pkg::NUM_W-1:0]  num,
    input  logic signed [ttdg_pkg::DEN_W-1:0]  den,
    output logic                               done,
    output logic signed [ttdg_pkg::NUM_W-1:0]  quot
);
    import ttdg_pkg::*;

    logic [DEN_W:0]       rem_reg, rem_next;
    logic [NUM_W-1:0]     q_reg, q_next;
    logic [DEN_W-1:0]     den_reg, den_next;
    logic                 neg_reg, neg_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DEN_W:0]       trial;
    logic                 fits;

    // One quotient bit per cycle, restoring
    assign trial = {rem_reg[DEN_W-1:0], q_reg[NUM_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        q_next    = q_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (go)
        begin
            q_next    = (num < 0) ? NUM_W'(-num) : NUM_W'(num);
            den_next  = (den < 0) ? DEN_W'(-den) : DEN_W'(den);
            neg_next  = num[NUM_W-1] ^ den[DEN_W-1];
            rem_next  = '0;
            cnt_next  = DIV_CNT_W'(NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? (trial - {1'b0, den_reg}) : trial;
            q_next   = {q_reg[NUM_W-2:0], fits};
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
        cnt_reg <= cnt_next;
    end

    assign done = done_reg;
    assign quot = neg_reg ? -$signed(q_reg) : $signed(q_reg);

    // Checks
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("divider done held longer than one cycle");

    a_go_free: assert property (@(posedge clk) disable iff (!rst_n)
        go |-> !busy_reg)
        else $error("divider started while busy");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("divider done without a division");

endmodule

/* src/turn_then_drive_goal_controller_unit.sv */
// Go-to-point controller for a differential-drive robot. A start word latches the target and
// start time; each tick word carries time and pose and yields one result word (status, and a
// velocity command when drive_valid is set); cancel ends the goal; command 3 is dropped with no
// result. Items are taken one at a time: item_stall is low only while the sequencer is idle.
// Start, cancel, idle, timed-out and no-pose ticks go from decode straight to finish. A tick
// with a pose runs the shared CORDIC unit twice (yaw, then bearing), each run normalising by
// up to 40 one-bit shifts and then rotating CORDIC_STEPS times; a spinning tick that needs
// the derivative term also waits for the bit-serial divider. The result register frees the
// input side while a result word waits to be taken.
module turn_then_drive_goal_controller_unit #(
    parameter int unsigned CORDIC_STEPS = ttdg_pkg::CORDIC_STEPS_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  item_valid,
    output logic                                  item_stall,
    input  ttdg_pkg::item_t                       item,
    output logic                                  result_valid,
    input  logic                                  result_stall,
    output ttdg_pkg::result_t                     result,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [ttdg_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [ttdg_pkg::CFG_DAT_W-1:0]        cfg_data
);
    import ttdg_pkg::*;

    // Configuration registers
    logic [15:0]        gain_p_reg, gain_d_reg, timeout_reg;
    logic [13:0]        head_tol_reg;
    logic [30:0]        arr_tol_reg;
    logic signed [15:0] cruise_reg;

    // Control state
    ctl_state_t         state_reg, state_next;
    logic               goal_active_reg, goal_active_next;
    logic               last_valid_reg, last_valid_next;
    logic [31:0]        last_time_reg, last_time_next;
    logic signed [ERR_W-1:0] last_err_reg, last_err_next;
    logic               result_valid_reg, result_valid_next;

    // Payload
    item_t              item_reg, item_next;
    logic signed [31:0] tx_reg, tx_next, ty_reg, ty_next;
    logic [31:0]        start_reg, start_next;
    logic signed [DX_W-1:0]  dx_reg, dx_next, dy_reg, dy_next;
    logic signed [31:0]      wz_reg, wz_next, zz_reg, zz_next;
    logic signed [ANG_W-1:0] yaw_reg, yaw_next;
    logic signed [E_W-1:0]   e_reg, e_next;
    logic signed [ERR_W-1:0] err_reg, err_next;
    logic signed [NUM_W-1:0] deriv_reg, deriv_next;
    logic signed [PP_W-1:0]  prod_p_reg, prod_p_next;
    logic signed [PD_W-1:0]  prod_d_reg, prod_d_next;
    logic [SQ_W-1:0]         sqx_reg, sqx_next, sqy_reg, sqy_next, tol_sq_reg, tol_sq_next;
    logic [SQ_W:0]           sum_reg, sum_next;
    result_t                 res_reg, res_next, result_reg, result_next;

    // Decode and arithmetic helpers
    logic                    accept;
    logic [31:0]             elapsed;
    logic                    goal_expired;
    logic signed [E_W-1:0]   e_rnd;
    logic [ERR_W-1:0]        aerr;
    logic                    spin;
    logic                    need_div;
    logic [DX_W-1:0]         ax, ay;
    logic                    too_far;
    logic signed [ACC_W-1:0] acc, acc_sh;
    logic signed [15:0]      turn_sat;
    logic                    out_free;

    // CORDIC, shared by yaw and bearing, and the divider
    logic                    cordic_go, cordic_done;
    logic signed [CIN_W-1:0] cordic_y, cordic_x;
    logic signed [ANG_W-1:0] cordic_angle;
    logic                    div_go, div_done;
    logic signed [NUM_W-1:0] div_num, div_quot;
    logic signed [DEN_W-1:0] div_den;

    assign accept    = item_valid && !item_stall;
    assign cfg_ready = 1'b1;
    assign out_free  = !result_valid_reg || !result_stall;

    assign elapsed      = item_reg.time_sec - start_reg;
    assign goal_expired = !elapsed[31] && (elapsed >= {16'd0, timeout_reg});

    assign e_rnd     = (e_reg + E_HALF) >>> 16;
    assign aerr      = (err_reg < 0) ? ERR_W'(-err_reg) : ERR_W'(err_reg);
    assign spin      = aerr > {{(ERR_W-14){1'b0}}, head_tol_reg};
    assign need_div  = last_valid_reg && (item_reg.time_sec != last_time_reg);

    assign ax        = (dx_reg < 0) ? DX_W'(-dx_reg) : DX_W'(dx_reg);
    assign ay        = (dy_reg < 0) ? DX_W'(-dy_reg) : DX_W'(dy_reg);
    assign too_far   = (ax[DX_W-1:31] != '0) || (ay[DX_W-1:31] != '0);

    assign acc       = (ACC_W'(prod_p_reg) <<< 2) + (ACC_W'(prod_d_reg) <<< 1)
                     + ACC_W'(prod_d_reg) + ACC_HALF;
    assign acc_sh    = acc >>> 14;
    assign turn_sat  = (acc_sh > SAT_HI) ? 16'sh7fff :
                       (acc_sh < SAT_LO) ? 16'sh8000 : acc_sh[15:0];

    // Unit operands
    assign cordic_go = (state_reg == S_YAW_GO) || (state_reg == S_BEAR_GO);
    assign cordic_y  = (state_reg == S_YAW_GO) ? (CIN_W'(wz_reg) <<< 1) : CIN_W'(dy_reg);
    assign cordic_x  = (state_reg == S_YAW_GO) ? (ONE_Q28 - (CIN_W'(zz_reg) <<< 1))
                                               : CIN_W'(dx_reg);
    assign div_go    = (state_reg == S_TEST) && spin && need_div;
    assign div_num   = NUM_W'(err_reg) - NUM_W'(last_err_reg);
    assign div_den   = $signed(item_reg.time_sec - last_time_reg);

    ttdg_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (cordic_go),
        .y_in  (cordic_y),
        .x_in  (cordic_x),
        .done  (cordic_done),
        .angle (cordic_angle)
    );

    ttdg_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (div_go),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg   <= RST_GAIN_P;
            gain_d_reg   <= RST_GAIN_D;
            head_tol_reg <= RST_HEAD_TOL;
            arr_tol_reg  <= RST_ARR_TOL;
            cruise_reg   <= RST_CRUISE;
            timeout_reg  <= RST_TIMEOUT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_GAIN_P:   gain_p_reg   <= cfg_data[15:0];
                CFG_GAIN_D:   gain_d_reg   <= cfg_data[15:0];
                CFG_HEAD_TOL: head_tol_reg <= cfg_data[13:0];
                CFG_ARR_TOL:  arr_tol_reg  <= cfg_data[30:0];
                CFG_CRUISE:   cruise_reg   <= $signed(cfg_data[15:0]);
                CFG_TIMEOUT:  timeout_reg  <= cfg_data[15:0];
                default:      gain_p_reg   <= gain_p_reg;
            endcase
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                priority if (item_reg.command == CMD_START || item_reg.command == CMD_CANCEL)
                    state_next = S_FINISH;
                else if (item_reg.command == CMD_TICK)
                begin
                    if (!goal_active_reg || goal_expired || !item_reg.pose_ready)
                        state_next = S_FINISH;
                    else
                        state_next = S_YAW_GO;
                end
                else
                    state_next = S_IDLE;
            end
            S_YAW_GO:    state_next = S_YAW_WAIT;
            S_YAW_WAIT:
            begin
                if (cordic_done)
                    state_next = S_BEAR_GO;
            end
            S_BEAR_GO:   state_next = S_BEAR_WAIT;
            S_BEAR_WAIT:
            begin
                if (cordic_done)
                    state_next = S_WRAP;
            end
            S_WRAP:      state_next = S_ROUND;
            S_ROUND:     state_next = S_TEST;
            S_TEST:
            begin
                priority if (!spin)
                    state_next = S_DIST_X;
                else if (need_div)
                    state_next = S_DIV_WAIT;
                else
                    state_next = S_MUL_P;
            end
            S_DIV_WAIT:
            begin
                if (div_done)
                    state_next = S_MUL_P;
            end
            S_MUL_P:     state_next = S_MUL_D;
            S_MUL_D:     state_next = S_SUM;
            S_SUM:       state_next = S_FINISH;
            S_DIST_X:    state_next = too_far ? S_FINISH : S_DIST_Y;
            S_DIST_Y:    state_next = S_DIST_T;
            S_DIST_T:    state_next = S_CMP;
            S_CMP:       state_next = S_FINISH;
            S_FINISH:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:     state_next = S_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        item_next         = item_reg;
        goal_active_next  = goal_active_reg;
        last_valid_next   = last_valid_reg;
        last_time_next    = last_time_reg;
        last_err_next     = last_err_reg;
        tx_next           = tx_reg;
        ty_next           = ty_reg;
        start_next        = start_reg;
        dx_next           = dx_reg;
        dy_next           = dy_reg;
        wz_next           = wz_reg;
        zz_next           = zz_reg;
        yaw_next          = yaw_reg;
        e_next            = e_reg;
        err_next          = err_reg;
        deriv_next        = deriv_reg;
        prod_p_next       = prod_p_reg;
        prod_d_next       = prod_d_reg;
        sqx_next          = sqx_reg;
        sqy_next          = sqy_reg;
        tol_sq_next       = tol_sq_reg;
        sum_next          = sum_reg;
        res_next          = res_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg;

        // Drop a taken result word
        if (result_valid_reg && !result_stall)
            result_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    item_next = item;
            end
            S_DECODE:
            begin
                res_next.drive_valid  = 1'b0;
                res_next.linear_speed = '0;
                res_next.turn_rate    = '0;
                priority if (item_reg.command == CMD_START)
                begin
                    tx_next          = item_reg.goal_x;
                    ty_next          = item_reg.goal_y;
                    start_next       = item_reg.time_sec;
                    goal_active_next = 1'b1;
                    last_valid_next  = 1'b0;
                    last_err_next    = '0;
                    res_next.status  = ST_WAIT;
                end
                else if (item_reg.command == CMD_CANCEL)
                begin
                    res_next.status  = goal_active_reg ? ST_CANCEL : ST_IDLE;
                    goal_active_next = 1'b0;
                end
                else if (item_reg.command == CMD_TICK)
                begin
                    priority if (!goal_active_reg)
                        res_next.status = ST_IDLE;
                    else if (goal_expired)
                    begin
                        res_next.status  = ST_TIMEOUT;
                        goal_active_next = 1'b0;
                    end
                    else if (!item_reg.pose_ready)
                        res_next.status = ST_WAIT;
                    else
                    begin
                        dx_next = DX_W'(tx_reg) - DX_W'(item_reg.pose_x);
                        dy_next = DX_W'(ty_reg) - DX_W'(item_reg.pose_y);
                        wz_next = item_reg.quat_w * item_reg.quat_z;
                        zz_next = item_reg.quat_z * item_reg.quat_z;
                    end
                end
                else
                    res_next = res_reg;
            end
            S_YAW_WAIT:
            begin
                if (cordic_done)
                    yaw_next = cordic_angle;
            end
            S_BEAR_WAIT:
            begin
                if (cordic_done)
                    e_next = E_W'(cordic_angle) - E_W'(yaw_reg);
            end
            S_WRAP:
            begin
                priority if (e_reg > PI_E)
                    e_next = e_reg - TWO_PI_E;
                else if (e_reg < -PI_E)
                    e_next = e_reg + TWO_PI_E;
                else
                    e_next = e_reg;
            end
            S_ROUND:
            begin
                err_next = e_rnd[ERR_W-1:0];
            end
            S_TEST:
            begin
                // Advance the PD history on spin ticks only
                if (spin)
                begin
                    deriv_next      = '0;
                    last_time_next  = item_reg.time_sec;
                    last_valid_next = 1'b1;
                    last_err_next   = err_reg;
                end
            end
            S_DIV_WAIT:
            begin
                if (div_done)
                    deriv_next = div_quot;
            end
            S_MUL_P:
            begin
                prod_p_next = $signed({1'b0, gain_p_reg}) * err_reg;
            end
            S_MUL_D:
            begin
                prod_d_next = $signed({1'b0, gain_d_reg}) * deriv_reg;
            end
            S_SUM:
            begin
                res_next.drive_valid  = 1'b1;
                res_next.linear_speed = '0;
                res_next.turn_rate    = turn_sat;
                res_next.status       = ST_SPIN;
            end
            S_DIST_X:
            begin
                if (too_far)
                begin
                    res_next.drive_valid  = 1'b1;
                    res_next.linear_speed = cruise_reg;
                    res_next.turn_rate    = '0;
                    res_next.status       = ST_DRIVE;
                end
                sqx_next = ax[30:0] * ax[30:0];
            end
            S_DIST_Y:
            begin
                sqy_next = ay[30:0] * ay[30:0];
            end
            S_DIST_T:
            begin
                tol_sq_next = arr_tol_reg * arr_tol_reg;
                sum_next    = {1'b0, sqx_reg} + {1'b0, sqy_reg};
            end
            S_CMP:
            begin
                res_next.drive_valid = 1'b1;
                res_next.turn_rate   = '0;
                if (sum_reg > {1'b0, tol_sq_reg})
                begin
                    res_next.linear_speed = cruise_reg;
                    res_next.status       = ST_DRIVE;
                end
                else
                begin
                    res_next.linear_speed = '0;
                    res_next.status       = ST_DONE;
                    goal_active_next      = 1'b0;
                end
            end
            S_FINISH:
            begin
                // Hand the word to the output register
                if (out_free)
                begin
                    result_next       = res_reg;
                    result_valid_next = 1'b1;
                end
            end
            default:
            begin
                res_next = res_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            goal_active_reg  <= 1'b0;
            last_valid_reg   <= 1'b0;
            last_time_reg    <= '0;
            last_err_reg     <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            goal_active_reg  <= goal_active_next;
            last_valid_reg   <= last_valid_next;
            last_time_reg    <= last_time_next;
            last_err_reg     <= last_err_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        tx_reg     <= tx_next;
        ty_reg     <= ty_next;
        start_reg  <= start_next;
        dx_reg     <= dx_next;
        dy_reg     <= dy_next;
        wz_reg     <= wz_next;
        zz_reg     <= zz_next;
        yaw_reg    <= yaw_next;
        e_reg      <= e_next;
        err_reg    <= err_next;
        deriv_reg  <= deriv_next;
        prod_p_reg <= prod_p_next;
        prod_d_reg <= prod_d_next;
        sqx_reg    <= sqx_next;
        sqy_reg    <= sqy_next;
        tol_sq_reg <= tol_sq_next;
        sum_reg    <= sum_next;
        res_reg    <= res_next;
        result_reg <= result_next;
    end

    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Checks
    a_no_drive_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && !result_reg.drive_valid
            |-> result_reg.linear_speed == '0 && result_reg.turn_rate == '0)
        else $error("speed set without a drive command");

    a_goal_end: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(goal_active_reg) |-> $past(state_reg) == S_DECODE || $past(state_reg) == S_CMP)
        else $error("goal ended outside decode or arrival");

    a_pd_history: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_MUL_P |-> last_valid_reg && last_err_reg == err_reg)
        else $error("PD history not advanced before turn rate");

endmodule

/* verif/ttdg_checker.sv */
module ttdg_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           item_valid,
    input  logic                           item_stall,
    input  ttdg_pkg::item_t                item,
    input  logic                           result_valid,
    input  logic                           result_stall,
    input  ttdg_pkg::result_t              result,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [ttdg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ttdg_pkg::CFG_DAT_W-1:0] cfg_data,
    output int                             fail_count,
    output int                             pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import ttdg_pkg::*;

    localparam longint PI_R      = 64'sd843314857;
    localparam longint TWO_PI_R  = 64'sd1686629713;
    localparam longint NORM_EDGE = 64'sd1 <<< 40;

    longint arctan_q28 [24];

    // Register copies
    logic [15:0]        kp;
    logic [15:0]        kd;
    logic [13:0]        head_tol;
    logic [30:0]        arr_tol;
    logic signed [15:0] cruise;
    logic [15:0]        timeout_s;

    // Goal and PD history
    bit                 goal_on;
    logic signed [31:0] tgt_x;
    logic signed [31:0] tgt_y;
    logic [31:0]        t_start;
    bit                 prev_t_ok;
    logic [31:0]        prev_t;
    longint             prev_err;

    result_t            drive_cmd_q [$];

    // Build arctangent table in Q28
    initial
    begin
        longint acc;
        longint term;
        int     ex;
        arctan_q28[0] = 64'sd210828714;
        for (int i = 1; i < 24; i++)
        begin
            acc = 0;
            for (int k = 0; 60 - (2 * k + 1) * i >= 0; k++)
            begin
                ex   = 60 - (2 * k + 1) * i;
                term = (64'sd1 <<< ex) / (2 * k + 1);
                acc  = (k % 2) ? acc - term : acc + term;
            end
            arctan_q28[i] = (acc + (64'sd1 <<< 31)) >>> 32;
        end
        kp = RST_GAIN_P; kd = RST_GAIN_D; head_tol = RST_HEAD_TOL;
        arr_tol = RST_ARR_TOL; cruise = RST_CRUISE; timeout_s = RST_TIMEOUT;
        goal_on = 0; tgt_x = 0; tgt_y = 0; t_start = 0;
        prev_t_ok = 0; prev_t = 0; prev_err = 0;
        fail_count = 0;
    end

    function automatic longint absval(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Vector angle in Q28 radians
    function automatic longint vec_angle(longint y, longint x);
        longint ang;
        longint xs;
        longint ys;
        ang = 0;
        if (x == 0 && y == 0)
            return 0;
        while (absval(x) < NORM_EDGE && absval(y) < NORM_EDGE)
        begin
            x = x * 2;
            y = y * 2;
        end
        if (x < 0)
        begin
            ang = (y >= 0) ? PI_R : -PI_R;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < CORDIC_STEPS_DEFAULT && i < 24; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0)
            begin
                x = x + ys; y = y - xs; ang = ang + arctan_q28[i];
            end
            else
            begin
                x = x - ys; y = y + xs; ang = ang - arctan_q28[i];
            end
        end
        return ang;
    endfunction

    // Work out the answer to one command word
    task automatic predict_word(input item_t w, output bit has, output result_t r);
        logic [31:0]          el;
        logic signed [31:0]   gap;
        longint               w_q, z_q, dx, dy, yaw, bear, e, err, deriv, acc;
        longint unsigned      ax, ay, d2;
        bit                   far;
        has = 1;
        r   = '0;
        case (w.command)
            CMD_START:
            begin
                tgt_x = w.goal_x; tgt_y = w.goal_y; t_start = w.time_sec;
                goal_on = 1; prev_t_ok = 0; prev_err = 0;
                r.status = ST_WAIT;
            end
            CMD_CANCEL:
            begin
                r.status = goal_on ? ST_CANCEL : ST_IDLE;
                goal_on = 0;
            end
            CMD_TICK:
            begin
                el = w.time_sec - t_start;
                if (!goal_on)
                    r.status = ST_IDLE;
                else if (!el[31] && el >= timeout_s)
                begin
                    goal_on  = 0;
                    r.status = ST_TIMEOUT;
                end
                else if (!w.pose_ready)
                    r.status = ST_WAIT;
                else
                begin
                    w_q  = w.quat_w;
                    z_q  = w.quat_z;
                    dx   = longint'(tgt_x) - longint'(w.pose_x);
                    dy   = longint'(tgt_y) - longint'(w.pose_y);
                    yaw  = vec_angle(2 * w_q * z_q, (64'sd1 <<< 28) - 2 * z_q * z_q);
                    bear = vec_angle(dy, dx);
                    e    = bear - yaw;
                    if (e > PI_R)
                        e = e - TWO_PI_R;
                    if (e < -PI_R)
                        e = e + TWO_PI_R;
                    err = (e + 32768) >>> 16;
                    r.drive_valid = 1;
                    if (absval(err) > longint'(head_tol))
                    begin
                        deriv = 0;
                        if (prev_t_ok && w.time_sec != prev_t)
                        begin
                            gap   = w.time_sec - prev_t;
                            deriv = (err - prev_err) / longint'(gap);
                        end
                        prev_t = w.time_sec; prev_t_ok = 1; prev_err = err;
                        acc = longint'(kp) * err * 4 + longint'(kd) * deriv * 3;
                        acc = (acc + 8192) >>> 14;
                        if (acc > 32767)
                            acc = 32767;
                        if (acc < -32768)
                            acc = -32768;
                        r.turn_rate = acc[15:0];
                        r.status    = ST_SPIN;
                    end
                    else
                    begin
                        ax = absval(dx);
                        ay = absval(dy);
                        if (ax >= 64'h8000_0000 || ay >= 64'h8000_0000)
                            far = 1;
                        else
                        begin
                            d2  = ax * ax + ay * ay;
                            far = d2 > longint'(arr_tol) * longint'(arr_tol);
                        end
                        if (far)
                        begin
                            r.linear_speed = cruise;
                            r.status       = ST_DRIVE;
                        end
                        else
                        begin
                            goal_on  = 0;
                            r.status = ST_DONE;
                        end
                    end
                end
            end
            default: has = 0;
        endcase
    endtask

    assign pending = drive_cmd_q.size();

    // Watch the channels: compare results, then predict new words
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        result_t pred;
        bit      has;
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                got = result;
                if (drive_cmd_q.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected result word %h", $time, got);
                end
                else
                begin
                    want = drive_cmd_q.pop_front();
                    if (got.drive_valid !== want.drive_valid ||
                        got.linear_speed !== want.linear_speed ||
                        got.turn_rate !== want.turn_rate || got.status !== want.status)
                    begin
                        fail_count++;
                        $display("%0t: mismatch expected dv=%0d lin=%0d turn=%0d st=%0d",
                                 $time, want.drive_valid, want.linear_speed,
                                 want.turn_rate, want.status);
                        $display("%0t:          actual   dv=%0d lin=%0d turn=%0d st=%0d",
                                 $time, got.drive_valid, got.linear_speed,
                                 got.turn_rate, got.status);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_GAIN_P:   kp        = cfg_data[15:0];
                    CFG_GAIN_D:   kd        = cfg_data[15:0];
                    CFG_HEAD_TOL: head_tol  = cfg_data[13:0];
                    CFG_ARR_TOL:  arr_tol   = cfg_data[30:0];
                    CFG_CRUISE:   cruise    = cfg_data[15:0];
                    CFG_TIMEOUT:  timeout_s = cfg_data[15:0];
                    default: ;
                endcase
            end
            if (item_valid && !item_stall)
            begin
                predict_word(item, has, pred);
                if (has)
                    drive_cmd_q.push_back(pred);
            end
        end
    end
endmodule

/* verif/tb_turn_then_drive_goal_controller_unit.sv */
module tb_turn_then_drive_goal_controller_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import ttdg_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int         SETTLE     = 200;

    logic                 clk;
    logic                 rst_n;
    logic                 item_valid;
    logic                 item_stall;
    item_t                item;
    logic                 result_valid;
    logic                 result_stall;
    result_t              result;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;
    int                   fail_count;
    int                   pending;

    int                   send_idle;
    int                   recv_idle;
    int                   words_sent;
    int                   settings_used;
    int                   cur_timeout;
    logic [31:0]          now_s;

    turn_then_drive_goal_controller_unit uut (.*);

    ttdg_checker chk (.*);

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Random stall on the result side
    always @(negedge clk)
        result_stall <= ($urandom_range(99) < recv_idle);

    function automatic item_t mk(logic [1:0] c, logic [31:0] t, logic pr,
                                 logic [31:0] px, logic [31:0] py,
                                 logic [15:0] qw, logic [15:0] qz,
                                 logic [31:0] gx, logic [31:0] gy);
        item_t w;
        w.command = c; w.time_sec = t; w.pose_ready = pr;
        w.pose_x = px; w.pose_y = py; w.quat_w = qw; w.quat_z = qz;
        w.goal_x = gx; w.goal_y = gy;
        return w;
    endfunction

    function automatic logic [15:0] rand_quat();
        return 16'($signed($urandom_range(32768)) - 16384);
    endfunction

    // Offer one word, holding it until taken
    task automatic send(input item_t w);
        while ($urandom_range(99) < send_idle)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        item       <= w;
        do
            @(posedge clk);
        while (item_stall);
        @(negedge clk);
        words_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Drain, then load a full register setting
    task automatic settle_and_load(input logic [15:0] p, input logic [15:0] d,
                                   input logic [13:0] h, input logic [30:0] a,
                                   input logic [15:0] c, input logic [15:0] t);
        item_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
        write_reg(CFG_GAIN_P, {16'd0, p});
        write_reg(CFG_GAIN_D, {16'd0, d});
        write_reg(CFG_HEAD_TOL, {18'd0, h});
        write_reg(CFG_ARR_TOL, {1'b0, a});
        write_reg(CFG_CRUISE, {16'd0, c});
        write_reg(CFG_TIMEOUT, {16'd0, t});
        cur_timeout = t;
        settings_used++;
    endtask

    // One goal: start, then words, mostly ticks closing in on the target
    task automatic goal_run(input int ticks);
        logic [31:0] gx, gy, px, py, t0, span;
        logic [15:0] qw, qz;
        int          pick;
        bit          aligned;
        aligned = $urandom_range(1);
        span    = 32'd1 << $urandom_range(20, 4);
        gx      = $urandom_range(1) ? $urandom : $urandom_range(span) - span / 2;
        gy      = $urandom_range(1) ? $urandom : $urandom_range(span) - span / 2;
        t0      = $urandom;
        now_s   = t0;
        send(mk(CMD_START, t0, 0, $urandom, $urandom, rand_quat(), rand_quat(), gx, gy));
        for (int k = 0; k < ticks; k++)
        begin
            pick  = $urandom_range(99);
            now_s = now_s + $urandom_range(2);
            span  = span >> 1;
            px    = gx - span - $urandom_range(15);
            py    = aligned ? gy + $urandom_range(2) - 1 : gy - span + $urandom_range(span);
            qw    = aligned ? 16'sd16384 : rand_quat();
            qz    = aligned ? 16'sd0 : rand_quat();
            if (pick < 3)
                send(mk(CMD_CANCEL, now_s, 1, px, py, qw, qz, $urandom, $urandom));
            else if (pick < 6)
                send(mk(CMD_UNUSED, now_s, 1, px, py, qw, qz, $urandom, $urandom));
            else if (pick < 9)
                send(mk(CMD_TICK, t0 + cur_timeout + $urandom_range(3), 1,
                        px, py, qw, qz, $urandom, $urandom));
            else if (pick < 12)
                send(mk(CMD_TICK, now_s, 0, px, py, qw, qz, $urandom, $urandom));
            else if (pick < 15)
                send(mk(CMD_TICK, t0 - $urandom_range(1, 5), 1, px, py, qw, qz,
                        $urandom, $urandom));
            else
                send(mk(CMD_TICK, now_s, 1, px, py, qw, qz, $urandom, $urandom));
        end
    endtask

    task automatic noise_word();
        send(mk(2'($urandom_range(3)), $urandom, 1'($urandom), $urandom, $urandom,
                rand_quat(), rand_quat(), $urandom, $urandom));
    endtask

    task automatic random_part(input int count);
        int goal_words;
        goal_words = 0;
        while (goal_words < count)
        begin
            if ($urandom_range(9) == 0)
            begin
                noise_word();
                goal_words++;
            end
            else
            begin
                goal_run($urandom_range(16, 4));
                goal_words += 10;
            end
        end
    endtask

    task automatic directed_part();
        // idle tick, idle cancel, unknown command
        send(mk(CMD_TICK, 32'd10, 1, 0, 0, 16'sd16384, 0, 0, 0));
        send(mk(CMD_CANCEL, 32'd10, 1, 0, 0, 16'sd16384, 0, 0, 0));
        send(mk(CMD_UNUSED, 32'hFFFF_FFFF, 1, '1, '1, '1, '1, '1, '1));
        // start, no pose, spin with derivative, equal time, backwards time
        send(mk(CMD_START, 32'd100, 0, 0, 0, 0, 0, 32'sd65536, 32'sd65536));
        send(mk(CMD_TICK, 32'd101, 0, 0, 0, 16'sd16384, 0, 0, 0));
        send(mk(CMD_TICK, 32'd102, 1, 0, 0, 16'sd16384, 0, 0, 0));
        send(mk(CMD_TICK, 32'd102, 1, 0, 0, 16'sd16384, 16'sd100, 0, 0));
        send(mk(CMD_TICK, 32'd105, 1, 0, 0, 16'sd11585, -16'sd11585, 0, 0));
        send(mk(CMD_TICK, 32'd99, 1, 0, 0, -16'sd16384, 0, 0, 0));
        send(mk(CMD_TICK, 32'd103, 1, 0, 0, 0, 16'sd16384, 0, 0));
        send(mk(CMD_TICK, 32'd104, 1, 0, 0, 0, -16'sd16384, 0, 0));
        // drive, then arrive with a zero displacement
        send(mk(CMD_TICK, 32'd106, 1, 0, 32'sd65536, 16'sd16384, 0, 0, 0));
        send(mk(CMD_TICK, 32'd107, 1, 32'sd65536, 32'sd65536, 16'sd16384, 0, 0, 0));
        // timeout exactly at the limit
        send(mk(CMD_START, 32'hFFFF_FF00, 1, 0, 0, 0, 0, 32'sh7FFF_FFFF, 32'sh8000_0000));
        send(mk(CMD_TICK, 32'hFFFF_FF00 + 360, 1, 0, 0, 16'sd16384, 0, 0, 0));
        send(mk(CMD_TICK, 32'd5, 1, 0, 0, 16'sd16384, 0, 0, 0));
        // huge displacement, then cancel while active
        send(mk(CMD_START, 32'd0, 1, 0, 0, 0, 0, 32'sh7FFF_FFFF, 32'sh0));
        send(mk(CMD_TICK, 32'd1, 1, 32'sh8000_0000, 32'sh0, 16'sd16384, 0, 0, 0));
        send(mk(CMD_TICK, 32'd2, 1, 32'sh8000_0000, 32'sh8000_0000,
                -16'sd16384, -16'sd16384, 0, 0));
        send(mk(CMD_CANCEL, 32'd3, 1, 0, 0, 0, 0, 0, 0));
        // start replacing an active goal
        send(mk(CMD_START, 32'd50, 1, 0, 0, 0, 0, 32'sh8000_0000, 32'sh7FFF_FFFF));
        send(mk(CMD_START, 32'd60, 1, 0, 0, 0, 0, 32'sd1000, 32'sd0));
        send(mk(CMD_TICK, 32'd61, 1, 32'sd999, 32'sd0, 16'sd16384, 0, 0, 0));
    endtask

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("** turn_then_drive_goal_controller_unit: FAILED **");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0; item_valid = 1'b0; item = '0; result_stall = 1'b0;
        cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
        send_idle = 12; recv_idle = 46;
        words_sent = 0; settings_used = 1; cur_timeout = 360; now_s = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        directed_part();
        random_part(70);
        settle_and_load(16'hFFFF, 16'hFFFF, 14'd0, 31'd0, 16'h8000, 16'd0);
        random_part(50);
        send_idle = 46; recv_idle = 12;
        settle_and_load(16'd0, 16'hFFFF, 14'd12868, 31'h7FFF_FFFF, 16'h7FFF, 16'hFFFF);
        random_part(90);
        settle_and_load(16'($urandom), 16'($urandom), 14'($urandom_range(12868)),
                        31'($urandom_range(1 << 20)), 16'($urandom),
                        16'($urandom_range(400, 5)));
        random_part(90);
        send_idle = 0; recv_idle = 0;
        settle_and_load(16'd4096, 16'd8192, 14'd400, 31'd65536, 16'd2048, 16'd30);
        random_part(90);
        settle_and_load(16'($urandom), 16'($urandom), 14'd12868,
                        31'($urandom_range(1 << 18)), 16'($urandom),
                        16'($urandom_range(400, 5)));
        random_part(90);

        // Drain
        item_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);

        $display("Sent %0d command words across %0d register settings,", words_sent,
                 settings_used);
        $display("with idle and stall on both channels; %0d mismatches.", fail_count);
        if (fail_count == 0)
            $display("** turn_then_drive_goal_controller_unit: PASSED **");
        else
            $display("** turn_then_drive_goal_controller_unit: FAILED **");
        $finish;
    end
endmodule
